// ===== rtl/sgre_pkg.sv =====
// Shared types, segment codes and protocol constants for the GetRequest encoder.
`default_nettype none
package sgre_pkg;

    typedef logic [4:0] count_t;
    typedef logic [3:0] seg_t;

    // Input item kinds
    localparam logic [1:0] KIND_COMM  = 2'd0;
    localparam logic [1:0] KIND_ARC   = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FEW_ARCS = 2'd1;
    localparam logic [1:0] STAT_COMM_OVF = 2'd2;
    localparam logic [1:0] STAT_OID_OVF  = 2'd3;

    // Controller states, which double as message segment selectors
    localparam seg_t S_IDLE = 4'd0;
    localparam seg_t S_HDR  = 4'd1;
    localparam seg_t S_COMM = 4'd2;
    localparam seg_t S_PDU  = 4'd3;
    localparam seg_t S_RID  = 4'd4;
    localparam seg_t S_TAIL = 4'd5;
    localparam seg_t S_OID  = 4'd6;
    localparam seg_t S_END  = 4'd7;
    localparam seg_t S_ERR  = 4'd8;

    // Last index within the fixed-length segments
    localparam count_t HDR_LAST  = 5'd6;
    localparam count_t PDU_LAST  = 5'd3;
    localparam count_t TAIL_LAST = 5'd12;
    localparam count_t END_LAST  = 5'd1;

    // BER tags and fixed bytes
    localparam logic [7:0] TAG_SEQ     = 8'h30;
    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_OCTSTR  = 8'h04;
    localparam logic [7:0] TAG_GETREQ  = 8'hA0;
    localparam logic [7:0] TAG_OID     = 8'h06;
    localparam logic [7:0] TAG_NULL    = 8'h05;
    localparam logic [7:0] OID_PREFIX  = 8'h2B;
    localparam logic [7:0] BYTE_ONE    = 8'h01;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;

    typedef struct packed {
        logic   load_comm;
        logic   load_arc;
        logic   latch_rid;
        logic   emit;
        logic   emit_err;
        logic   last;
        logic   clear;
        seg_t   seg;
        count_t idx;
    } cmd_t;

    typedef struct packed {
        count_t     comm_count;
        count_t     oid_count;
        logic [1:0] rid_len;
        logic       fault;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/snmp_get_request_encoder.sv =====
// SNMPv2c GetRequest BER encoder: top level joining controller and datapath.
//
// Input stream (s_*): s_tuser selects the request kind, s_tdata carries its value.
//   Community byte and OID arc requests are taken one per cycle while idle. The first
//   two arcs stand for the fixed 0x2B prefix; later arcs are stored base-128.
//   A build request carries the request id in s_tdata[15:0] and starts emission.
// Output stream (m_*): one message byte per request on m_tdata, m_tlast on the
//   final byte, m_tuser status 0. A build with a recorded error, or with fewer
//   than three arcs, emits a single request with byte 0, m_tlast 1 and the status.
// Timing: a taken build moves the controller to its header segment; it then walks
//   the segments one byte a cycle through the output register while m_tready holds.
//   A message is 28 to 61 bytes with the default limits. s_tready is low from build
//   acceptance until the last byte is registered.
// Stalls: a low m_tready holds the output register and freezes the sequencer.
// Reset: counters, error and state clear, version_code returns to 1. After every
//   build all loaded content is discarded.
// cfg_wr_en / cfg_wr_data write version_code; write only while idle.
`default_nettype none
module snmp_get_request_encoder #(
    parameter int COMMUNITY_MAX = 16,
    parameter int OID_BYTES_MAX = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // version_code
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // data[31:0]
    input  wire logic [1:0]  s_tuser,       // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // out_byte[7:0]
    output logic             m_tlast,
    output logic [1:0]       m_tuser        // status[1:0]
);
    import sgre_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sgre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgre_datapath #(
        .COMMUNITY_MAX (COMMUNITY_MAX),
        .OID_BYTES_MAX (OID_BYTES_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/sgre_ctrl.sv =====
// Sequencing state machine: load dispatch, message segment walk and error result.
`default_nettype none
module sgre_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,
    input  wire sgre_pkg::stat_t stat,
    output sgre_pkg::cmd_t     cmd
);
    import sgre_pkg::*;

    seg_t   state_reg, state_next;
    count_t idx_reg, idx_next;
    logic   seg_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        unique case (state_reg)
            S_HDR:   seg_done = (idx_reg == HDR_LAST);
            S_COMM:  seg_done = ((idx_reg + 5'd1) == stat.comm_count);
            S_PDU:   seg_done = (idx_reg == PDU_LAST);
            S_RID:   seg_done = ((idx_reg + 5'd1) == {3'b000, stat.rid_len});
            S_TAIL:  seg_done = (idx_reg == TAIL_LAST);
            S_OID:   seg_done = ((idx_reg + 5'd1) == stat.oid_count);
            S_END:   seg_done = (idx_reg == END_LAST);
            default: seg_done = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.seg    = state_reg;
        cmd.idx    = idx_reg;
        unique case (state_reg) inside
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        KIND_COMM: cmd.load_comm = 1'b1;
                        KIND_ARC:  cmd.load_arc  = 1'b1;
                        KIND_BUILD: begin
                            cmd.latch_rid = 1'b1;
                            idx_next      = '0;
                            state_next    = stat.fault ? S_ERR : S_HDR;
                        end
                        default: ;
                    endcase
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.emit_err = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_HDR, S_COMM, S_PDU, S_RID, S_TAIL, S_OID, S_END: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (seg_done) begin
                        idx_next = '0;
                        unique case (state_reg)
                            S_HDR:  state_next = (stat.comm_count == '0) ? S_PDU : S_COMM;
                            S_COMM: state_next = S_PDU;
                            S_PDU:  state_next = S_RID;
                            S_RID:  state_next = S_TAIL;
                            S_TAIL: state_next = (stat.oid_count == '0) ? S_END : S_OID;
                            S_OID:  state_next = S_END;
                            default: begin
                                cmd.last   = 1'b1;
                                cmd.clear  = 1'b1;
                                state_next = S_IDLE;
                            end
                        endcase
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/sgre_datapath.sv =====
// Stores, counters, length arithmetic, byte selection and output register.
`default_nettype none
module sgre_datapath #(
    parameter int COMMUNITY_MAX = 16,
    parameter int OID_BYTES_MAX = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [7:0]     cfg_wr_data,
    input  wire logic [31:0]    s_tdata,
    input  wire sgre_pkg::cmd_t cmd,
    output sgre_pkg::stat_t     stat,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);
    import sgre_pkg::*;

    localparam int CIW = (COMMUNITY_MAX > 1) ? $clog2(COMMUNITY_MAX) : 1;
    localparam int OIW = (OID_BYTES_MAX > 1) ? $clog2(OID_BYTES_MAX) : 1;
    localparam count_t     COMM_LIMIT = count_t'(COMMUNITY_MAX);
    localparam logic [5:0] OID_LIMIT  = 6'(OID_BYTES_MAX);

    logic [7:0]  comm_store [COMMUNITY_MAX];
    logic [7:0]  oid_store  [OID_BYTES_MAX];
    count_t      comm_count_reg;
    count_t      oid_count_reg;
    logic [1:0]  arc_count_reg;
    logic [1:0]  err_reg;
    logic [7:0]  version_reg;
    logic [15:0] rid_reg;

    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;
    logic [1:0]  m_user_reg;

    // base-128 split of an arc
    logic [6:0]  grp [5];
    logic [2:0]  ngrp;
    logic [5:0]  oid_fill;
    logic        oid_fits;
    logic        wen   [5];
    logic [5:0]  waddr [5];
    logic [7:0]  wbyte [5];
    logic [2:0]  gsel  [5];

    logic [1:0]  rid_len;
    logic [1:0]  rid_pos;
    logic [7:0]  oid_len, vb_len, vbl_len, pdu_len, total_len;
    logic [7:0]  byte_sel;
    logic [1:0]  fault_code;

    assign grp[0] = s_tdata[6:0];
    assign grp[1] = s_tdata[13:7];
    assign grp[2] = s_tdata[20:14];
    assign grp[3] = s_tdata[27:21];
    assign grp[4] = {3'b000, s_tdata[31:28]};

    always_comb begin
        if (s_tdata[31:28] != '0)      ngrp = 3'd5;
        else if (s_tdata[27:21] != '0) ngrp = 3'd4;
        else if (s_tdata[20:14] != '0) ngrp = 3'd3;
        else if (s_tdata[13:7] != '0)  ngrp = 3'd2;
        else                           ngrp = 3'd1;
    end

    assign oid_fill = {1'b0, oid_count_reg} + {3'b000, ngrp};
    assign oid_fits = (oid_fill <= OID_LIMIT);

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            wen[i]   = (3'(i) < ngrp);
            waddr[i] = {1'b0, oid_count_reg} + 6'(i);
            gsel[i]  = ngrp - 3'd1 - 3'(i);
            wbyte[i] = {(3'(i) + 3'd1 < ngrp), grp[gsel[i]]};
        end
    end

    // stores: entries above the counts are never read, so no clearing
    always_ff @(posedge aclk) begin
        if (cmd.load_comm && (comm_count_reg < COMM_LIMIT)) begin
            comm_store[comm_count_reg[CIW-1:0]] <= s_tdata[7:0];
        end
        if (cmd.load_arc && (arc_count_reg == 2'd2 || arc_count_reg == 2'd3) && oid_fits) begin
            for (int i = 0; i < 5; i++) begin
                if (wen[i]) begin
                    oid_store[waddr[i][OIW-1:0]] <= wbyte[i];
                end
            end
        end
        if (cmd.latch_rid) begin
            rid_reg <= s_tdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comm_count_reg <= '0;
            oid_count_reg  <= '0;
            arc_count_reg  <= '0;
            err_reg        <= STAT_OK;
        end else if (cmd.clear) begin
            comm_count_reg <= '0;
            oid_count_reg  <= '0;
            arc_count_reg  <= '0;
            err_reg        <= STAT_OK;
        end else if (cmd.load_comm) begin
            if (comm_count_reg < COMM_LIMIT) begin
                comm_count_reg <= comm_count_reg + 5'd1;
            end else if (err_reg == STAT_OK) begin
                err_reg <= STAT_COMM_OVF;
            end
        end else if (cmd.load_arc) begin
            if (arc_count_reg != 2'd3) begin
                arc_count_reg <= arc_count_reg + 2'd1;
            end
            if (arc_count_reg == 2'd2 || arc_count_reg == 2'd3) begin
                if (oid_fits) begin
                    oid_count_reg <= oid_fill[4:0];
                end else if (err_reg == STAT_OK) begin
                    err_reg <= STAT_OID_OVF;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= BYTE_ONE;
        end else if (cfg_wr_en) begin
            version_reg <= cfg_wr_data;
        end
    end

    // length fields
    always_comb begin
        if (rid_reg < 16'h0080)      rid_len = 2'd1;
        else if (rid_reg < 16'h8000) rid_len = 2'd2;
        else                         rid_len = 2'd3;
    end

    assign rid_pos   = rid_len - 2'd1 - cmd.idx[1:0];
    assign oid_len   = {3'b000, oid_count_reg} + 8'd1;
    assign vb_len    = oid_len + 8'd4;
    assign vbl_len   = vb_len + 8'd2;
    assign pdu_len   = vbl_len + {6'b0, rid_len} + 8'd10;
    assign total_len = pdu_len + {3'b000, comm_count_reg} + 8'd7;

    always_comb begin
        byte_sel = BYTE_ZERO;
        case (cmd.seg)
            S_HDR: begin
                case (cmd.idx)
                    5'd0:    byte_sel = TAG_SEQ;
                    5'd1:    byte_sel = total_len;
                    5'd2:    byte_sel = TAG_INT;
                    5'd3:    byte_sel = BYTE_ONE;
                    5'd4:    byte_sel = version_reg;
                    5'd5:    byte_sel = TAG_OCTSTR;
                    default: byte_sel = {3'b000, comm_count_reg};
                endcase
            end
            S_COMM: byte_sel = comm_store[cmd.idx[CIW-1:0]];
            S_PDU: begin
                case (cmd.idx)
                    5'd0:    byte_sel = TAG_GETREQ;
                    5'd1:    byte_sel = pdu_len;
                    5'd2:    byte_sel = TAG_INT;
                    default: byte_sel = {6'b0, rid_len};
                endcase
            end
            S_RID: begin
                case (rid_pos)
                    2'd0:    byte_sel = rid_reg[7:0];
                    2'd1:    byte_sel = rid_reg[15:8];
                    default: byte_sel = BYTE_ZERO;
                endcase
            end
            S_TAIL: begin
                case (cmd.idx) inside
                    5'd0, 5'd3: byte_sel = TAG_INT;
                    5'd1, 5'd4: byte_sel = BYTE_ONE;
                    5'd2, 5'd5: byte_sel = BYTE_ZERO;
                    5'd6, 5'd8: byte_sel = TAG_SEQ;
                    5'd7:       byte_sel = vbl_len;
                    5'd9:       byte_sel = vb_len;
                    5'd10:      byte_sel = TAG_OID;
                    5'd11:      byte_sel = oid_len;
                    default:    byte_sel = OID_PREFIX;
                endcase
            end
            S_OID: byte_sel = oid_store[cmd.idx[OIW-1:0]];
            S_END: byte_sel = (cmd.idx == '0) ? TAG_NULL : BYTE_ZERO;
            default: byte_sel = BYTE_ZERO;
        endcase
    end

    assign fault_code = (err_reg != STAT_OK) ? err_reg : STAT_FEW_ARCS;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_err) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= byte_sel;
            m_last_reg <= cmd.last;
            m_user_reg <= STAT_OK;
        end else if (cmd.emit_err) begin
            m_data_reg <= BYTE_ZERO;
            m_last_reg <= 1'b1;
            m_user_reg <= fault_code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    assign stat.comm_count = comm_count_reg;
    assign stat.oid_count  = oid_count_reg;
    assign stat.rid_len    = rid_len;
    assign stat.fault      = (err_reg != STAT_OK) || (arc_count_reg != 2'd3);
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule
`default_nettype wire
